// ===== src/fifo_with_indexed_removal_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed-removal queue
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_INDEXED_REMOVAL_TOP_ASSERT_SVH
`define FIFO_WITH_INDEXED_REMOVAL_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define FWIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define FWIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fwir_pkg.sv =====
// ----------------------------------------------------------------------------
// fwir_pkg
// Types and codes shared by the indexed-removal queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fwir_pkg;

  // Operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Word returned by a pop from an empty queue
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam int unsigned COUNT_W = 5;

  // Input transaction
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
    logic [3:0]         position;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic signed [31:0]   data_out;
    logic [1:0]           status;
    logic [COUNT_W-1:0]   count;
  } out_t;

  // Controller state, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== src/fwir_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwir_ctrl
// Sequencer: capture a transaction, execute it, then present the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fwir_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output fwir_pkg::ctrl_cmd_t     cmd_o,
  output logic                    busy_o,
  output logic                    valid_o
);

  fwir_pkg::ctrl_state_e state_q, state_d;
  logic                  accept;

  // Accept whenever no operation is executing
  assign accept = start_i && !busy_o;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      fwir_pkg::S_IDLE: begin
        if (accept) state_d = fwir_pkg::S_EXEC;
      end
      fwir_pkg::S_EXEC: begin
        state_d = fwir_pkg::S_DONE;
      end
      fwir_pkg::S_DONE: begin
        state_d = accept ? fwir_pkg::S_EXEC : fwir_pkg::S_IDLE;
      end
      default: begin
        state_d = fwir_pkg::S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fwir_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Drive commands and handshake flags
  assign busy_o     = (state_q == fwir_pkg::S_EXEC);
  assign valid_o    = (state_q == fwir_pkg::S_DONE);
  assign cmd_o.load = accept;
  assign cmd_o.exec = busy_o;

endmodule

`default_nettype wire

// ===== src/fwir_dpath.sv =====
// ----------------------------------------------------------------------------
// fwir_dpath
// Compacted word store with parallel shift, fill count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwir_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fwir_pkg::ctrl_cmd_t cmd_i,
  input  wire fwir_pkg::in_t      item_i,
  output fwir_pkg::out_t          result_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (FW > 4) ? FW : 4;

  fwir_pkg::in_t      item_q;
  fwir_pkg::out_t     res_q, res_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [31:0]        store_q [DEPTH];

  logic               is_full;
  logic               is_empty;
  logic               pos_ok;
  logic               do_push;
  logic               do_take;
  logic [AW-1:0]      rm_idx;

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
  end

  // Decode the operation
  always_comb begin
    is_full  = (fill_q == FW'(DEPTH));
    is_empty = (fill_q == '0);
    pos_ok   = (item_q.opcode == fwir_pkg::OP_REMOVE) && (item_q.position != '0) &&
               (CMPW'(item_q.position) < CMPW'(fill_q)) &&
               (CMPW'(item_q.position) < CMPW'(DEPTH));
    rm_idx   = pos_ok ? AW'(item_q.position) : '0;
    do_push  = 1'b0;
    do_take  = 1'b0;
    fill_d   = fill_q;
    res_d.data_out = '0;
    res_d.status   = fwir_pkg::ST_OK;
    case (item_q.opcode)
      fwir_pkg::OP_PUSH: begin
        if (is_full) begin
          res_d.status = fwir_pkg::ST_FULL;
        end else begin
          do_push = 1'b1;
          fill_d  = fill_q + 1'b1;
        end
      end
      fwir_pkg::OP_POP, fwir_pkg::OP_REMOVE: begin
        if (pos_ok || !is_empty) begin
          do_take        = 1'b1;
          fill_d         = fill_q - 1'b1;
          res_d.data_out = store_q[rm_idx];
        end else begin
          res_d.data_out = fwir_pkg::INT_MAX;
          res_d.status   = fwir_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
    res_d.count = fwir_pkg::COUNT_W'(fill_d);
  end

  // Hold the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.exec) begin
      fill_q <= fill_d;
    end
  end

  // Advance each cell: close the gap above the removed word, or take a push
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (cmd_i.exec) begin
          if (do_take && (AW'(g) >= rm_idx)) begin
            store_q[g] <= store_q[g+1];
          end else if (do_push && (FW'(g) == fill_q)) begin
            store_q[g] <= item_q.value;
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (cmd_i.exec && do_push && (FW'(g) == fill_q)) begin
          store_q[g] <= item_q.value;
        end
      end
    end
  end

  // Register the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== src/fifo_with_indexed_removal_top.sv =====
// ----------------------------------------------------------------------------
// fifo_with_indexed_removal_top
// Queue of signed words with push, front pop and remove at a position.
//
//   channel   handshake              payload
//   command   start / busy           cmd_i    (fwir_pkg::in_t)
//   result    result_valid_o strobe  result_o (fwir_pkg::out_t)
//
// A transaction is captured, then executed in the EXEC state, in which the cells from
// the removed word up shift toward the front in parallel; the result strobes the next cycle.
// A new transaction is taken in the result cycle.
// Reset clears the fill count; the store needs no clearing.
// The receiver cannot stall; each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_with_indexed_removal_top_assert.svh"

module fifo_with_indexed_removal_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire fwir_pkg::in_t cmd_i,
  output logic               result_valid_o,
  output fwir_pkg::out_t     result_o
);

  fwir_pkg::ctrl_cmd_t ctrl_cmd;

  // Sequencer
  fwir_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (ctrl_cmd),
    .busy_o  (busy),
    .valid_o (result_valid_o)
  );

  // Store and result path
  fwir_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ctrl_cmd),
    .item_i   (cmd_i),
    .result_o (result_o)
  );

  // Check sequencing and the empty-queue answer
  `FWIR_ASSERT_NEXT(a_accept_exec, start && !busy, busy, "accepted transaction not executed")
  `FWIR_ASSERT_NEXT(a_exec_result, busy, result_valid_o && !busy, "execution gave no result")
  `FWIR_ASSERT_NOW(a_result_idle, result_valid_o, !busy, "result during execution")
  `FWIR_ASSERT_NOW(a_empty_word,
      result_valid_o && (result_o.status == fwir_pkg::ST_EMPTY),
      (result_o.data_out == fwir_pkg::INT_MAX) && (result_o.count == '0),
      "empty pop result malformed")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: indexed-removal queue testbench
// Drives push, pop and remove-at commands, including the unused opcode, into
// fifo_with_indexed_removal_top with random idle gaps. A behavioral queue
// predicts each result. A monitor compares every strobed result, field by
// field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = 16;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam int unsigned N_RANDOM  = 650;

  typedef struct packed {
    fwir_pkg::in_t cmd;
    int unsigned   gap;
  } queued_cmd_t;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  fwir_pkg::in_t  cmd_i  = '0;
  logic           busy;
  logic           result_valid_o;
  fwir_pkg::out_t result_o;

  // Commands waiting to be issued, and results predicted but not yet seen
  queued_cmd_t    pending_cmds[$];
  fwir_pkg::out_t expected_results[$];

  // Behavioral copy of the queue contents
  logic signed [31:0] held_words[DEPTH];
  int unsigned        held_fill = 0;

  int unsigned idle_cycles = 0;
  int unsigned fail_cnt    = 0;

  fifo_with_indexed_removal_top #(.DEPTH(DEPTH)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the behavioral queue and return its result
  task automatic apply_queue_op(input fwir_pkg::in_t c, output fwir_pkg::out_t r);
    int unsigned idx;
    bit          take;
    r      = '0;
    r.status = fwir_pkg::ST_OK;
    take   = 1'b0;
    idx    = 0;
    case (c.opcode)
      fwir_pkg::OP_PUSH: begin
        if (held_fill >= DEPTH) begin
          r.status = fwir_pkg::ST_FULL;
        end else begin
          held_words[held_fill] = c.value;
          held_fill++;
        end
      end
      fwir_pkg::OP_POP, fwir_pkg::OP_REMOVE: begin
        // Out-of-range or zero position falls back to a front pop
        if (c.opcode == fwir_pkg::OP_REMOVE && c.position > 0 &&
            c.position < held_fill) begin
          idx  = c.position;
          take = 1'b1;
        end else if (held_fill == 0) begin
          r.data_out = fwir_pkg::INT_MAX;
          r.status   = fwir_pkg::ST_EMPTY;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (take) begin
      r.data_out = held_words[idx];
      for (int unsigned i = idx; i + 1 < held_fill; i++) begin
        held_words[i] = held_words[i + 1];
      end
      held_fill--;
    end
    r.count = held_fill[fwir_pkg::COUNT_W-1:0];
  endtask

  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(39))
      0:       return INT_MIN;
      1:       return fwir_pkg::INT_MAX;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(logic [1:0] op, logic signed [31:0] val, logic [3:0] pos,
                         int unsigned gap);
    queued_cmd_t q;
    q.cmd.opcode   = op;
    q.cmd.value    = val;
    q.cmd.position = pos;
    q.gap          = gap;
    pending_cmds.push_back(q);
  endtask

  // Issue commands; predict each transaction as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin : drive
    queued_cmd_t    nxt;
    fwir_pkg::out_t predicted;
    if (!rst_ni) begin
      start       <= 1'b0;
      cmd_i       <= '0;
      idle_cycles <= 0;
    end else if (start && !busy) begin
      apply_queue_op(cmd_i, predicted);
      expected_results.push_back(predicted);
      idle_cycles <= 0;
      // Keep start high for a back-to-back transaction
      if (pending_cmds.size() != 0 && pending_cmds[0].gap == 0) begin
        nxt = pending_cmds.pop_front();
        cmd_i <= nxt.cmd;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_cmds.size() != 0) begin
      if (idle_cycles < pending_cmds[0].gap) begin
        idle_cycles <= idle_cycles + 1;
      end else begin
        nxt = pending_cmds.pop_front();
        cmd_i       <= nxt.cmd;
        start       <= 1'b1;
        idle_cycles <= 0;
      end
    end
  end

  // Compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin : check
    fwir_pkg::out_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected result data %0d status %0d count %0d", $realtime,
                   result_o.data_out, result_o.status, result_o.count);
      end else begin
        exp_r = expected_results.pop_front();
        if (result_o.data_out !== exp_r.data_out || result_o.status !== exp_r.status ||
            result_o.count !== exp_r.count) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"%0t: mismatch: expected data %0d status %0d count %0d, ",
                      "got data %0d status %0d count %0d"},
                     $realtime, exp_r.data_out, exp_r.status, exp_r.count,
                     result_o.data_out, result_o.status, result_o.count);
        end
      end
    end
  end

  // Build the stimulus, then wait for the last result
  initial begin
    logic signed [31:0] dir_vals[6];
    int unsigned n;
    int unsigned burst;
    int unsigned push_pct;
    int unsigned roll;
    bit          calm;
    logic [1:0]  op;

    dir_vals = '{INT_MIN, fwir_pkg::INT_MAX, 32'sd0, -32'sd1, 32'sh5555_5555,
                 32'shAAAA_AAAA};

    // Empty queue: pop, remove at zero and at a high position, unused opcode
    add_cmd(fwir_pkg::OP_POP, '0, 4'd0, 0);
    add_cmd(fwir_pkg::OP_REMOVE, '0, 4'd0, 0);
    add_cmd(fwir_pkg::OP_REMOVE, '0, 4'd15, 1);
    add_cmd(OP_UNUSED, -32'sd1, 4'd15, 0);
    // Fill to capacity with extreme words, then push one more into a full queue
    for (int i = 0; i <= DEPTH; i++) begin
      add_cmd(fwir_pkg::OP_PUSH, (i < 6) ? dir_vals[i] : 32'sh1000 + i,
              4'($urandom), 0);
    end
    // Full queue: remove the tail, remove past the count, remove inside, pop
    add_cmd(fwir_pkg::OP_REMOVE, '0, 4'd15, 0);
    add_cmd(fwir_pkg::OP_REMOVE, '0, 4'd15, 2);
    add_cmd(fwir_pkg::OP_REMOVE, '0, 4'd1, 0);
    add_cmd(fwir_pkg::OP_POP, '0, 4'd9, 0);
    add_cmd(OP_UNUSED, '0, 4'd0, 0);

    // Random bursts that lean toward filling, draining or holding the level
    n = 0;
    while (n < N_RANDOM) begin
      burst = $urandom_range(45, 15);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 20;
      endcase
      calm = ($urandom_range(3) == 0);
      for (int unsigned k = 0; k < burst; k++) begin
        roll = $urandom_range(99);
        if ($urandom_range(49) == 0) op = OP_UNUSED;
        else if (roll < push_pct)   op = fwir_pkg::OP_PUSH;
        else if (roll[0])           op = fwir_pkg::OP_POP;
        else                        op = fwir_pkg::OP_REMOVE;
        add_cmd(op, pick_value(), 4'($urandom_range(15)), pick_gap(calm));
        n++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    fail_cnt += expected_results.size();
    if (fail_cnt == 0) begin
      $display("** fifo_with_indexed_removal_top: PASSED **");
    end else begin
      $display("** fifo_with_indexed_removal_top: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("** fifo_with_indexed_removal_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/fwir_pkg.sv
src/fwir_ctrl.sv
src/fwir_dpath.sv
src/fifo_with_indexed_removal_top.sv
bench/tb_top.sv
